// File: rtl/nps_pkg.sv
package nps_pkg;

    // Saturation value of a squared distance.
    localparam logic [63:0] DIST_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // Rounding constant for the Q1.16 cosine product (one half of an LSB).
    localparam logic [49:0] COS_ROUND = 50'h0_0000_0000_8000;

    // Depth of the queue between the distance pipeline and the argmin stage.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_HERE_LAT   = 2'd0;
    localparam logic [1:0] CFG_HERE_LON   = 2'd1;
    localparam logic [1:0] CFG_COS_LAT    = 2'd2;
    localparam logic [1:0] CFG_HERE_VALID = 2'd3;

    typedef struct packed {
        logic [31:0] here_lat;
        logic [31:0] here_lon;
        logic [16:0] cos_lat;
        logic        here_valid;
    } cfg_t;

    // One scored candidate as it travels from the front end to the back end.
    typedef struct packed {
        logic [63:0] dist_sq;
        logic [15:0] index;
        logic        scored;
        logic        last;
    } item_t;

    // Square of a magnitude, saturated to all ones once it no longer fits.
    function automatic logic [63:0] sat_square(input logic [33:0] m);
        logic [31:0] lo;
        logic [63:0] sq;
        lo = m[31:0];
        sq = lo * lo;
        if (m[33:32] != 2'b00) begin
            sq = DIST_MAX;
        end
        return sq;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? DIST_MAX : s[63:0];
    endfunction

    // Magnitude of the difference of two 32-bit signed values (fits 33 bits).
    function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (~d + 33'd1) : d;
    endfunction

endpackage

// File: rtl/nps_front.sv
module nps_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  nps_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_point_lat,
    input  logic signed [31:0]  s_point_lon,
    input  logic [15:0]         s_point_index,
    input  logic                s_point_valid,
    input  logic                s_last,
    input  logic                q_full,
    output logic                q_push,
    output nps_pkg::item_t      q_push_item
);

    logic        advance;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [32:0] mlon1_reg, mlat1_reg;
    logic [15:0] idx1_reg, idx2_reg, idx3_reg;
    logic        sc1_reg, sc2_reg, sc3_reg;
    logic        last1_reg, last2_reg, last3_reg;
    logic [33:0] dx2_reg;
    logic [63:0] sqlat2_reg, sqlat3_reg, sqdx3_reg;
    nps_pkg::item_t item4_reg;

    logic [49:0] prod;
    logic [49:0] rnd;

    // The whole pipeline moves together; it holds only when its output cannot enter the queue.
    assign advance = !v4_reg || !q_full;
    assign s_ready = advance;

    assign prod = mlon1_reg * cfg.cos_lat;
    assign rnd  = prod + nps_pkg::COS_ROUND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mlon1_reg  <= nps_pkg::abs_diff(s_point_lon, cfg.here_lon);
            mlat1_reg  <= nps_pkg::abs_diff(s_point_lat, cfg.here_lat);
            idx1_reg   <= s_point_index;
            sc1_reg    <= s_point_valid && cfg.here_valid;
            last1_reg  <= s_last;

            dx2_reg    <= rnd[49:16];
            sqlat2_reg <= nps_pkg::sat_square({1'b0, mlat1_reg});
            idx2_reg   <= idx1_reg;
            sc2_reg    <= sc1_reg;
            last2_reg  <= last1_reg;

            sqdx3_reg  <= nps_pkg::sat_square(dx2_reg);
            sqlat3_reg <= sqlat2_reg;
            idx3_reg   <= idx2_reg;
            sc3_reg    <= sc2_reg;
            last3_reg  <= last2_reg;

            item4_reg.dist_sq <= nps_pkg::sat_add(sqdx3_reg, sqlat3_reg);
            item4_reg.index   <= idx3_reg;
            item4_reg.scored  <= sc3_reg;
            item4_reg.last    <= last3_reg;
        end
    end

    assign q_push      = v4_reg && !q_full;
    assign q_push_item = item4_reg;

endmodule

// File: rtl/nps_queue.sv
module nps_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  nps_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output nps_pkg::item_t q_item
);

    nps_pkg::item_t                      mem_reg [nps_pkg::QUEUE_DEPTH];
    logic [nps_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [nps_pkg::QUEUE_CNT_W-1:0]     count_reg;

    assign full    = (count_reg == nps_pkg::QUEUE_CNT_W'(nps_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == nps_pkg::QUEUE_PTR_W'(nps_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == nps_pkg::QUEUE_PTR_W'(nps_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> !pop) else $error("queue read while empty");

endmodule

// File: rtl/nps_back.sv
module nps_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  nps_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [15:0]    m_nearest_index,
    output logic [63:0]    m_nearest_dist_sq,
    output logic           m_found
);

    logic [63:0] best_dist_reg;
    logic [15:0] best_index_reg;
    logic        have_best_reg;
    logic        m_valid_reg;
    logic [15:0] out_index_reg;
    logic [63:0] out_dist_reg;
    logic        out_found_reg;

    logic        take;
    logic [63:0] dist_upd;
    logic [15:0] index_upd;
    logic        have_upd;

    // A last item needs the output register free; any other item drains at once.
    assign q_pop = q_valid && (!q_item.last || !m_valid_reg || m_ready);

    always_comb begin
        take      = q_item.scored && (!have_best_reg || (q_item.dist_sq < best_dist_reg));
        dist_upd  = take ? q_item.dist_sq : best_dist_reg;
        index_upd = take ? q_item.index   : best_index_reg;
        have_upd  = have_best_reg || take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg  <= nps_pkg::DIST_MAX;
            best_index_reg <= '0;
            have_best_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (q_item.last) begin
                    m_valid_reg    <= 1'b1;
                    best_dist_reg  <= nps_pkg::DIST_MAX;
                    best_index_reg <= '0;
                    have_best_reg  <= 1'b0;
                end else begin
                    best_dist_reg  <= dist_upd;
                    best_index_reg <= index_upd;
                    have_best_reg  <= have_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            out_index_reg <= have_upd ? index_upd : 16'd0;
            out_dist_reg  <= have_upd ? dist_upd  : nps_pkg::DIST_MAX;
            out_found_reg <= have_upd;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_nearest_index   = out_index_reg;
    assign m_nearest_dist_sq = out_dist_reg;
    assign m_found           = out_found_reg;

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_nearest_index == 16'd0 &&
                                   m_nearest_dist_sq == nps_pkg::DIST_MAX))
        else $error("empty search reported a candidate");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |=> (!have_best_reg && m_valid))
        else $error("search state not cleared after final transaction");
    a_idle_best: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_best_reg |-> (best_dist_reg == nps_pkg::DIST_MAX))
        else $error("best distance held without a candidate");

endmodule

// File: rtl/nearest_point_search.sv
// Streaming nearest-point search. Each input transaction carries one candidate point
// (signed Q3.28 radian latitude and longitude, a 16-bit index, a valid mark and a last
// mark); the block scores it against the configured current position with the
// equirectangular squared distance (dlon*cos_lat)^2 + dlat^2 in Q.56, saturated at all
// ones, and keeps the earliest strictly closest valid candidate. The transaction marked
// last produces one result transaction with the index, distance and found flag (index 0,
// distance all ones and found 0 when nothing valid was seen) and starts a new search.
// Candidates are accepted at one per clock cycle while s_ready is high: a four-stage
// distance pipeline (the 33x17 cosine multiply and the two 32x32 squarers set its depth)
// feeds a four-entry queue, and a compare-and-keep stage drains that queue; the result
// register is loaded as the last candidate leaves the queue. Input ready drops only
// when the queue is full, which happens while a finished result is not taken.
// Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata while no
// search is in flight; all of them reset to zero, so the position is invalid after reset.
module nearest_point_search (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_point_lat,
    input  logic signed [31:0]  s_point_lon,
    input  logic [15:0]         s_point_index,
    input  logic                s_point_valid,
    input  logic                s_last,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_nearest_index,
    output logic [63:0]         m_nearest_dist_sq,
    output logic                m_found
);

    nps_pkg::cfg_t  cfg_reg;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    nps_pkg::item_t q_push_item;
    nps_pkg::item_t q_item;

    // Configuration registers. The datapath reads them directly, which is safe only if the
    // user changes them only while the pipeline and queue are empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                nps_pkg::CFG_HERE_LAT:   cfg_reg.here_lat   <= cfg_wdata;
                nps_pkg::CFG_HERE_LON:   cfg_reg.here_lon   <= cfg_wdata;
                nps_pkg::CFG_COS_LAT:    cfg_reg.cos_lat    <= cfg_wdata[16:0];
                nps_pkg::CFG_HERE_VALID: cfg_reg.here_valid <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Front end: accepts candidates and computes their saturated squared distances.
    nps_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_lat   (s_point_lat),
        .s_point_lon   (s_point_lon),
        .s_point_index (s_point_index),
        .s_point_valid (s_point_valid),
        .s_last        (s_last),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_item   (q_push_item)
    );

    // Short queue that lets the distance pipeline keep running while a result waits.
    nps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back end: running minimum, tie rule and the result register.
    nps_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_nearest_index   (m_nearest_index),
        .m_nearest_dist_sq (m_nearest_dist_sq),
        .m_found           (m_found)
    );

endmodule
